// ===== rtl/core/mcsp_pkg.sv =====
// ----------------------------------------------------------------------------
// mcsp_pkg
// Shared types, constants and round functions for the counter-state probe.
// ----------------------------------------------------------------------------
package mcsp_pkg;

    localparam int FIRST_PROBE_STEP_DEF  = 6;
    localparam int SECOND_PROBE_STEP_DEF = 8;
    localparam int ROUNDS                = 64;
    localparam int REG_IDX_W             = 3;
    localparam int REG_W                 = 64;

    // register indexes of the configuration port
    typedef enum logic [REG_IDX_W-1:0] {
        REG_A_HIGH = 3'd0,
        REG_A_LOW  = 3'd1,
        REG_B_HIGH = 3'd2,
        REG_B_LOW  = 3'd3,
        REG_C_HIGH = 3'd4,
        REG_C_LOW  = 3'd5
    } reg_idx_t;

    // width codes of a result
    localparam logic [1:0] CODE_NONE = 2'd0;
    localparam logic [1:0] CODE_A    = 2'd1;
    localparam logic [1:0] CODE_B    = 2'd2;
    localparam logic [1:0] CODE_C    = 2'd3;

    typedef logic [127:0] ctr_t;
    typedef logic [31:0]  word_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
    } md5_st_t;

    localparam word_t H0 = 32'h67452301;
    localparam word_t H1 = 32'hefcdab89;
    localparam word_t H2 = 32'h98badcfe;
    localparam word_t H3 = 32'h10325476;

    localparam word_t MD5_K [ROUNDS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int MD5_ROT [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    // one step of the byte counter, byte 0 in the top bits
    function automatic ctr_t ctr_advance(input ctr_t c, input logic ordinary);
        ctr_t        r;
        logic        carry;
        logic [7:0]  old_b;
        r = c;
        if (ordinary)
        begin
            r = c + 128'd1;
        end
        else
        begin
            carry = 1'b1;
            for (int i = 0; i < 16; i++)
            begin
                old_b = c[8*i +: 8];
                r[8*i +: 8] = carry ? old_b + 8'd1 : old_b;
                if (old_b != 8'd0)
                begin
                    carry = 1'b0;
                end
            end
        end
        return r;
    endfunction

    // message word g of the single padded block holding 16 counter bytes
    function automatic word_t msg_word(input ctr_t m, input int g);
        word_t w;
        w = '0;
        if (g < 4)
        begin
            for (int j = 0; j < 4; j++)
            begin
                w[8*j +: 8] = m[127 - 8*(4*g + j) -: 8];
            end
        end
        else if (g == 4)
        begin
            w = 32'h0000_0080;
        end
        else if (g == 14)
        begin
            w = 32'h0000_0080;
        end
        return w;
    endfunction

    function automatic int msg_index(input int i);
        int g;
        if (i < 16)
        begin
            g = i;
        end
        else if (i < 32)
        begin
            g = (5*i + 1) % 16;
        end
        else if (i < 48)
        begin
            g = (3*i + 5) % 16;
        end
        else
        begin
            g = (7*i) % 16;
        end
        return g;
    endfunction

    function automatic word_t rotl(input word_t x, input int s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic md5_st_t md5_round(input md5_st_t s, input ctr_t m, input int i);
        md5_st_t r;
        word_t   f;
        word_t   t;
        if (i < 16)
        begin
            f = (s.b & s.c) | (~s.b & s.d);
        end
        else if (i < 32)
        begin
            f = (s.d & s.b) | (~s.d & s.c);
        end
        else if (i < 48)
        begin
            f = s.b ^ s.c ^ s.d;
        end
        else
        begin
            f = s.c ^ (s.b | ~s.d);
        end
        t   = s.a + f + MD5_K[i] + msg_word(m, msg_index(i));
        r.a = s.d;
        r.d = s.c;
        r.c = s.b;
        r.b = s.b + rotl(t, MD5_ROT[((i / 16) * 4) + (i % 4)]);
        return r;
    endfunction

    function automatic word_t bswap32(input word_t x);
        return {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

endpackage

// ===== rtl/core/mcsp_ifs.sv =====
// ----------------------------------------------------------------------------
// mcsp interfaces
// Request and result channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface mcsp_req_if;
    logic        valid;
    logic        ready;
    logic [63:0] state_high;
    logic [63:0] state_low;
    logic        mode;

    modport source (output valid, output state_high, output state_low, output mode,
                    input ready);
    modport sink   (input valid, input state_high, input state_low, input mode,
                    output ready);
endinterface

interface mcsp_res_if;
    logic       valid;
    logic       ready;
    logic       hit;
    logic [1:0] width_code;

    modport source (output valid, output hit, output width_code, input ready);
    modport sink   (input valid, input hit, input width_code, output ready);
endinterface

// ===== rtl/core/mcsp_advance.sv =====
// ----------------------------------------------------------------------------
// mcsp_advance
// Counter pipeline: one counter step per stage, snapshots at both probe steps.
// ----------------------------------------------------------------------------
module mcsp_advance
    import mcsp_pkg::*;
#(
    parameter int FIRST_PROBE_STEP  = FIRST_PROBE_STEP_DEF,
    parameter int SECOND_PROBE_STEP = SECOND_PROBE_STEP_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  logic valid_in,
    input  ctr_t ctr_in,
    input  logic mode_in,
    output logic valid_out,
    output ctr_t snap_f,
    output ctr_t snap_s
);

    localparam int LAST = (FIRST_PROBE_STEP > SECOND_PROBE_STEP) ?
                          FIRST_PROBE_STEP : SECOND_PROBE_STEP;

    logic vld_reg  [LAST+1];
    ctr_t ctr_reg  [LAST+1];
    ctr_t f_reg    [LAST+1];
    ctr_t s_reg    [LAST+1];
    logic mode_reg [LAST+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctr_reg[0]  <= ctr_in;
            f_reg[0]    <= ctr_in;
            s_reg[0]    <= ctr_in;
            mode_reg[0] <= mode_in;
        end
    end

    for (genvar j = 1; j <= LAST; j++)
    begin : g_step
        ctr_t adv_next;
        assign adv_next = ctr_advance(ctr_reg[j-1], mode_reg[j-1]);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[j] <= vld_reg[j-1];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ctr_reg[j]  <= adv_next;
                mode_reg[j] <= mode_reg[j-1];
                f_reg[j]    <= (j == FIRST_PROBE_STEP)  ? adv_next : f_reg[j-1];
                s_reg[j]    <= (j == SECOND_PROBE_STEP) ? adv_next : s_reg[j-1];
            end
        end
    end

    assign valid_out = vld_reg[LAST];
    assign snap_f    = f_reg[LAST];
    assign snap_s    = s_reg[LAST];

endmodule

// ===== rtl/core/mcsp_md5.sv =====
// ----------------------------------------------------------------------------
// mcsp_md5
// Unrolled MD5 of a 16-byte block: one round per stage, then the final add.
// ----------------------------------------------------------------------------
module mcsp_md5
    import mcsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  ctr_t          msg,
    output logic          valid_out,
    output logic [127:0]  digest
);

    md5_st_t st_reg  [ROUNDS];
    ctr_t    msg_reg [ROUNDS];
    logic    vld_reg [ROUNDS];
    md5_st_t st_prev [ROUNDS];
    ctr_t    msg_prev[ROUNDS];
    logic    vld_prev[ROUNDS];

    logic [127:0] digest_reg;
    logic         dvld_reg;

    for (genvar r = 0; r < ROUNDS; r++)
    begin : g_round
        md5_st_t st_next;

        if (r == 0)
        begin : g_first
            assign st_prev[r]  = '{a: H0, b: H1, c: H2, d: H3};
            assign msg_prev[r] = msg;
            assign vld_prev[r] = valid_in;
        end
        else
        begin : g_rest
            assign st_prev[r]  = st_reg[r-1];
            assign msg_prev[r] = msg_reg[r-1];
            assign vld_prev[r] = vld_reg[r-1];
        end

        assign st_next = md5_round(st_prev[r], msg_prev[r], r);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[r] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[r] <= vld_prev[r];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[r]  <= st_next;
                msg_reg[r] <= msg_prev[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dvld_reg <= 1'b0;
        end
        else if (en)
        begin
            dvld_reg <= vld_reg[ROUNDS-1];
        end
    end

    // fold in the chaining value and lay the bytes out big-endian
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            digest_reg <= {bswap32(st_reg[ROUNDS-1].a + H0),
                           bswap32(st_reg[ROUNDS-1].b + H1),
                           bswap32(st_reg[ROUNDS-1].c + H2),
                           bswap32(st_reg[ROUNDS-1].d + H3)};
        end
    end

    assign valid_out = dvld_reg;
    assign digest    = digest_reg;

endmodule

// ===== rtl/core/md5_counter_state_probe.sv =====
// ----------------------------------------------------------------------------
// md5_counter_state_probe
// Steps a 128-bit byte counter, hashes it at two probe steps, matches anchors.
// ----------------------------------------------------------------------------
// Path: counter stages, 64 MD5 round stages, digest add and output reg.
// Throughput: one request per cycle; the whole pipeline holds while a result
//   waits at the output and the sink is not ready.
// Reset: asynchronous, clears all valid bits and the anchors to zero.
module md5_counter_state_probe
    import mcsp_pkg::*;
#(
    parameter int FIRST_PROBE_STEP  = FIRST_PROBE_STEP_DEF,
    parameter int SECOND_PROBE_STEP = SECOND_PROBE_STEP_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    mcsp_req_if.sink             request,
    mcsp_res_if.source           result,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [REG_W-1:0]     wr_data
);

    // anchor registers
    logic [REG_W-1:0] a_hi_reg, a_lo_reg, b_hi_reg, b_lo_reg, c_hi_reg, c_lo_reg;

    // pipeline enable: advance unless a finished result is stuck at the output
    logic en;

    logic adv_valid;
    ctr_t snap_f, snap_s;
    logic vf, vs;
    logic [127:0] dig_f, dig_s;

    logic       out_valid_reg, out_valid_next;
    logic       hit_reg, hit_next;
    logic [1:0] code_reg, code_next;

    logic match_a, match_b, match_c;

    assign en            = !out_valid_reg || result.ready;
    assign request.ready = en;

    // configuration writes; an index past the list is dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_hi_reg <= '0;
            a_lo_reg <= '0;
            b_hi_reg <= '0;
            b_lo_reg <= '0;
            c_hi_reg <= '0;
            c_lo_reg <= '0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_A_HIGH: a_hi_reg <= wr_data;
                REG_A_LOW:  a_lo_reg <= wr_data;
                REG_B_HIGH: b_hi_reg <= wr_data;
                REG_B_LOW:  b_lo_reg <= wr_data;
                REG_C_HIGH: c_hi_reg <= wr_data;
                REG_C_LOW:  c_lo_reg <= wr_data;
                default:    ;
            endcase
        end
    end

    // counter stages; both snapshots leave together
    mcsp_advance #(
        .FIRST_PROBE_STEP  (FIRST_PROBE_STEP),
        .SECOND_PROBE_STEP (SECOND_PROBE_STEP)
    ) u_adv (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (request.valid),
        .ctr_in    ({request.state_high, request.state_low}),
        .mode_in   (request.mode),
        .valid_out (adv_valid),
        .snap_f    (snap_f),
        .snap_s    (snap_s)
    );

    // two hash pipelines run in lock step
    mcsp_md5 u_md5_f (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (adv_valid),
        .msg       (snap_f),
        .valid_out (vf),
        .digest    (dig_f)
    );

    mcsp_md5 u_md5_s (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (adv_valid),
        .msg       (snap_s),
        .valid_out (vs),
        .digest    (dig_s)
    );

    assign match_a = (dig_f == {a_hi_reg, a_lo_reg});
    assign match_b = (dig_f == {b_hi_reg, b_lo_reg});
    assign match_c = (dig_s == {c_hi_reg, c_lo_reg});

    // report the first match in step order; the later probe loses a tie
    always_comb
    begin
        code_next = CODE_NONE;
        if (FIRST_PROBE_STEP > SECOND_PROBE_STEP)
        begin
            if (match_c)
            begin
                code_next = CODE_C;
            end
            else if (match_a)
            begin
                code_next = CODE_A;
            end
            else if (match_b)
            begin
                code_next = CODE_B;
            end
        end
        else
        begin
            if (match_a)
            begin
                code_next = CODE_A;
            end
            else if (match_b)
            begin
                code_next = CODE_B;
            end
            else if (match_c)
            begin
                code_next = CODE_C;
            end
        end
        hit_next       = (code_next != CODE_NONE);
        out_valid_next = en ? (vf && vs) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the result while the sink stalls
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            hit_reg  <= hit_next;
            code_reg <= code_next;
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.hit        = hit_reg;
    assign result.width_code = code_reg;

endmodule

// ===== rtl/core/mcsp_checker.sv =====
// ----------------------------------------------------------------------------
// mcsp_checker
// Port-level checks of the probe, bound to the top level.
// ----------------------------------------------------------------------------
module mcsp_checker
    import mcsp_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic       hit,
    input logic [1:0] width_code
);

    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hit == (width_code != CODE_NONE)))
        else $error("hit disagrees with width code");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !in_ready)
        else $error("request taken while result stalled");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(width_code)))
        else $error("stalled result changed");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("request refused with empty output");

endmodule

bind md5_counter_state_probe mcsp_checker u_mcsp_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ready   (request.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .hit        (result.hit),
    .width_code (result.width_code)
);
